/* design/assert_macros.svh */
// Assertion macros shared by the checker modules of the design.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* design/gau_pkg.sv */
// Types and constants of the grouped aggregate update block.
// No dependencies; used by the interfaces, the store and the top level.
package gau_pkg;

  localparam int SLOT_W  = 10;
  localparam int ROW_W   = 48;
  localparam int COUNT_W = 32;
  localparam int VALUE_W = 64;
  localparam int MODE_W  = 3;

  // Aggregate mode codes; the remaining codes leave every slot unchanged.
  localparam logic [MODE_W-1:0] MODE_COUNT_ALL   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_COUNT_VALID = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SUM         = 3'd2;
  localparam logic [MODE_W-1:0] MODE_MIN         = 3'd3;
  localparam logic [MODE_W-1:0] MODE_MAX         = 3'd4;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [VALUE_W-1:0] VALUE_POS_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic [VALUE_W-1:0] VALUE_NEG_MAX = {1'b1, {(VALUE_W-1){1'b0}}};

  // One row of group state.
  typedef struct packed {
    logic [COUNT_W-1:0]        count;
    logic signed [VALUE_W-1:0] value;
  } gau_entry_t;

endpackage

/* design/gau_if.sv */
// Handshake channels of the grouped aggregate update block.
// Depends on gau_pkg for field widths.
interface gau_in_if;
  logic                             valid;
  logic                             ready;
  logic [gau_pkg::SLOT_W-1:0]       group_slot;
  logic signed [gau_pkg::ROW_W-1:0] row_value;
  logic                             value_valid;
  logic                             batch_last;

  modport source (output valid, group_slot, row_value, value_valid, batch_last,
                  input ready);
  modport sink (input valid, group_slot, row_value, value_valid, batch_last,
                output ready);
endinterface

interface gau_out_if;
  logic                               valid;
  logic                               ready;
  logic [gau_pkg::COUNT_W-1:0]        slot_count;
  logic signed [gau_pkg::VALUE_W-1:0] slot_value;
  logic                               slot_changed;
  logic                               batch_done;

  modport source (output valid, slot_count, slot_value, slot_changed, batch_done,
                  input ready);
  modport sink (input valid, slot_count, slot_value, slot_changed, batch_done,
                output ready);
endinterface

/* design/gau_mem.sv */
// Group state memory: one write port, one read port with registered data.
// Depends on gau_pkg for the entry type.
module gau_mem #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic                clk,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   rd_addr,
  output gau_pkg::gau_entry_t rd_data,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  gau_pkg::gau_entry_t wr_data
);

  gau_pkg::gau_entry_t mem [DEPTH];
  gau_pkg::gau_entry_t rd_data_r;

  // Read returns the old entry when the same address is written this cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* design/grouped_aggregate_update_top.sv */
// Grouped aggregate update: per-row update of a group-by table (count, sum, min, max).
// Depends on gau_pkg, gau_if (gau_in_if, gau_out_if) and gau_mem.
//
// Each item names a group slot and carries a Q31.16 value with a null flag; the
// block updates that slot's 32-bit count and Q47.16 accumulator according to
// cfg mode and returns one result item with the slot's state after the update.
// Throughput is one item per cycle while out_ch takes every result. The result
// passes through the update stage and the output register before it is offered
// on out_ch. The rate is set by the single read-modify-write loop around the
// state memory: an item reads its row in the accept cycle, the update is computed
// from the registered row and written back as the item leaves the update stage,
// and a back-to-back item on the same slot picks up the fresh row from a
// forwarding register holding the most recent write. After reset the block runs
// a clearing pass that zeros the memory one row per cycle; in_ch.ready stays low
// during that pass. Write cfg_wr_data (mode) only while the block is idle. Slots
// at or above GROUP_SLOTS yield a zero result and change nothing.
module grouped_aggregate_update_top #(
  parameter int GROUP_SLOTS = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  gau_in_if.sink                     in_ch,
  gau_out_if.source                  out_ch,
  input  logic                       cfg_wr_en,
  input  logic [gau_pkg::MODE_W-1:0] cfg_wr_data
);

  localparam int ADDR_W = $clog2(GROUP_SLOTS);

  // Mode register
  logic [gau_pkg::MODE_W-1:0] mode_r;

  // Clearing pass
  logic              clearing_r;
  logic [ADDR_W-1:0] clr_idx_r;

  // Update stage (item whose row is being read)
  logic                                s1_vld_r;
  logic [ADDR_W-1:0]                   s1_addr_r;
  logic                                s1_ok_r;
  logic signed [gau_pkg::ROW_W-1:0]    s1_row_r;
  logic                                s1_valid_r;
  logic                                s1_last_r;

  // Forwarding of the most recent write
  logic                fwd_vld_r;
  logic [ADDR_W-1:0]   fwd_addr_r;
  gau_pkg::gau_entry_t fwd_data_r;

  // Output register
  logic                                out_vld_r;
  logic [gau_pkg::COUNT_W-1:0]         out_count_r;
  logic signed [gau_pkg::VALUE_W-1:0]  out_value_r;
  logic                                out_changed_r;
  logic                                out_last_r;

  logic                accept;
  logic                s1_adv;
  logic [31:0]         slot_wide;
  logic                slot_ok;
  gau_pkg::gau_entry_t rd_data;
  gau_pkg::gau_entry_t old_e;
  gau_pkg::gau_entry_t new_e;
  logic                s1_wr;
  logic                mem_wr_en;
  logic [ADDR_W-1:0]   mem_wr_addr;
  gau_pkg::gau_entry_t mem_wr_data;
  logic [gau_pkg::VALUE_W-1:0] x_ext;
  logic [gau_pkg::VALUE_W-1:0] sum_raw;
  logic [gau_pkg::VALUE_W-1:0] sum_sat;
  logic [gau_pkg::COUNT_W-1:0] cnt_bump;
  logic                        x_lt_old;

  // Handshake: advance the update stage when the output register is free or drains.
  assign s1_adv = !out_vld_r || out_ch.ready;
  assign in_ch.ready = !clearing_r && (!s1_vld_r || s1_adv);
  assign accept = in_ch.valid && in_ch.ready;

  assign slot_wide = {{(32-gau_pkg::SLOT_W){1'b0}}, in_ch.group_slot};
  assign slot_ok   = slot_wide < 32'(GROUP_SLOTS);

  gau_mem #(
    .DEPTH  (GROUP_SLOTS),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (slot_wide[ADDR_W-1:0]),
    .rd_data (rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  // Read-modify-write of the slot row.
  always_comb begin
    old_e = (fwd_vld_r && (fwd_addr_r == s1_addr_r)) ? fwd_data_r : rd_data;
    x_ext = {{(gau_pkg::VALUE_W-gau_pkg::ROW_W){s1_row_r[gau_pkg::ROW_W-1]}}, s1_row_r};
    cnt_bump = (old_e.count == gau_pkg::COUNT_MAX) ? old_e.count
                                                    : old_e.count + 1'b1;
    sum_raw = old_e.value + x_ext;
    // Saturate when both operands share a sign that the sum lost.
    if ((old_e.value[gau_pkg::VALUE_W-1] == x_ext[gau_pkg::VALUE_W-1]) &&
        (sum_raw[gau_pkg::VALUE_W-1] != old_e.value[gau_pkg::VALUE_W-1])) begin
      sum_sat = old_e.value[gau_pkg::VALUE_W-1] ? gau_pkg::VALUE_NEG_MAX
                                                : gau_pkg::VALUE_POS_MAX;
    end else begin
      sum_sat = sum_raw;
    end
    x_lt_old = $signed(x_ext) < $signed(old_e.value);

    new_e = old_e;
    case (mode_r)
      gau_pkg::MODE_COUNT_ALL: begin
        new_e.count = cnt_bump;
      end
      gau_pkg::MODE_COUNT_VALID: begin
        if (s1_valid_r) new_e.count = cnt_bump;
      end
      gau_pkg::MODE_SUM: begin
        if (s1_valid_r) begin
          new_e.count = cnt_bump;
          new_e.value = sum_sat;
        end
      end
      gau_pkg::MODE_MIN: begin
        if (s1_valid_r) begin
          new_e.count = cnt_bump;
          // Seed an empty slot with the first valid value.
          if (old_e.count == '0 || x_lt_old) new_e.value = x_ext;
        end
      end
      gau_pkg::MODE_MAX: begin
        if (s1_valid_r) begin
          new_e.count = cnt_bump;
          if (old_e.count == '0 || ($signed(old_e.value) < $signed(x_ext))) begin
            new_e.value = x_ext;
          end
        end
      end
      default: begin
        new_e = old_e;
      end
    endcase
  end

  assign s1_wr = s1_vld_r && s1_adv && s1_ok_r;

  // Clearing pass owns the write port until it finishes.
  assign mem_wr_en   = clearing_r || s1_wr;
  assign mem_wr_addr = clearing_r ? clr_idx_r : s1_addr_r;
  assign mem_wr_data = clearing_r ? '0 : new_e;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= gau_pkg::MODE_COUNT_ALL;
      clearing_r <= 1'b1;
      clr_idx_r  <= '0;
      s1_vld_r   <= 1'b0;
      fwd_vld_r  <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) mode_r <= cfg_wr_data;
      if (clearing_r) begin
        clr_idx_r <= clr_idx_r + 1'b1;
        if (clr_idx_r == ADDR_W'(GROUP_SLOTS - 1)) clearing_r <= 1'b0;
      end
      if (accept) begin
        s1_vld_r <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_wr) fwd_vld_r <= 1'b1;
      if (s1_vld_r && s1_adv) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr_r  <= slot_wide[ADDR_W-1:0];
      s1_ok_r    <= slot_ok;
      s1_row_r   <= in_ch.row_value;
      s1_valid_r <= in_ch.value_valid;
      s1_last_r  <= in_ch.batch_last;
    end
    if (s1_wr) begin
      fwd_addr_r <= s1_addr_r;
      fwd_data_r <= new_e;
    end
    if (s1_vld_r && s1_adv) begin
      out_last_r <= s1_last_r;
      if (s1_ok_r) begin
        out_count_r   <= new_e.count;
        out_value_r   <= new_e.value;
        out_changed_r <= (new_e.count != old_e.count) || (new_e.value != old_e.value);
      end else begin
        // Drop out-of-range rows with an empty result.
        out_count_r   <= '0;
        out_value_r   <= '0;
        out_changed_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.slot_count   = out_count_r;
  assign out_ch.slot_value   = out_value_r;
  assign out_ch.slot_changed = out_changed_r;
  assign out_ch.batch_done   = out_last_r;

endmodule

/* design/gau_checker.sv */
// Port-level checks of grouped_aggregate_update_top, bound to the top level.
// Depends on assert_macros.svh and gau_pkg.
`include "assert_macros.svh"

module gau_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [gau_pkg::COUNT_W-1:0] out_slot_count,
  input logic                        out_slot_changed
);

  // A stalled result stays offered.
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // A stalled result keeps its count.
  `ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_slot_count))

  // The clearing pass blocks input right after reset.
  `ASSERT_SAME(a_clear_block, clk, rst_n, $past(!rst_n), !in_ready)

  // A changed slot has counted at least one row.
  `ASSERT_SAME(a_changed_count, clk, rst_n, out_valid && out_slot_changed,
               out_slot_count != '0)

endmodule

bind grouped_aggregate_update_top gau_checker u_gau_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_slot_count   (out_ch.slot_count),
  .out_slot_changed (out_ch.slot_changed)
);

/* dv/grouped_aggregate_update_top_tb.sv */
// Testbench for grouped_aggregate_update_top: directed and random rows through every mode code,
// each result checked field by field against a behavioral model of the per-slot state.
// Depends on gau_pkg, the gau_in_if / gau_out_if channels and the design top level.
module grouped_aggregate_update_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOT_COUNT    = 1024;
  localparam int CLK_PERIOD    = 4;
  localparam int RESET_CYCLES  = 3;
  // Cycles to wait after the last result has come back.
  localparam int SETTLE_CYCLES = 6;
  // Cycles without any handshake; covers the clearing pass after reset several times over.
  localparam int STALL_LIMIT   = 4000;
  localparam int RANDOM_BLOCKS = 9;
  localparam int BLOCK_ROWS    = 105;

  // Mode codes that the block treats as no-ops.
  localparam logic [gau_pkg::MODE_W-1:0] MODE_UNDEF_LO  = 3'd5;
  localparam logic [gau_pkg::MODE_W-1:0] MODE_UNDEF_MID = 3'd6;
  localparam logic [gau_pkg::MODE_W-1:0] MODE_UNDEF_HI  = 3'd7;

  localparam logic signed [gau_pkg::ROW_W-1:0] ROW_POS_MAX =
    {1'b0, {(gau_pkg::ROW_W-1){1'b1}}};
  localparam logic signed [gau_pkg::ROW_W-1:0] ROW_NEG_MAX =
    {1'b1, {(gau_pkg::ROW_W-1){1'b0}}};

  typedef struct packed {
    logic [gau_pkg::SLOT_W-1:0]       slot;
    logic signed [gau_pkg::ROW_W-1:0] value;
    logic                             vvalid;
    logic                             last;
  } row_item_t;

  typedef struct packed {
    logic [gau_pkg::COUNT_W-1:0]        count;
    logic signed [gau_pkg::VALUE_W-1:0] value;
    logic                               changed;
    logic                               done;
  } slot_result_t;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       cfg_wr_en;
  logic [gau_pkg::MODE_W-1:0] cfg_wr_data;

  gau_in_if  in_ch();
  gau_out_if out_ch();

  grouped_aggregate_update_top #(
    .GROUP_SLOTS(SLOT_COUNT)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Rows waiting to go out, and the slot updates the block still owes us, oldest first.
  row_item_t    rows_to_send[$];
  slot_result_t slot_updates_due[$];

  // Shadow copy of the block's slot state and mode register.
  bit [gau_pkg::COUNT_W-1:0]        count_mirror [SLOT_COUNT];
  bit signed [gau_pkg::VALUE_W-1:0] value_mirror [SLOT_COUNT];
  logic [gau_pkg::MODE_W-1:0]       agg_mode_mirror;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned mismatch_count = 0;
  int unsigned rows_accepted = 0;
  int unsigned results_checked = 0;
  int unsigned stall_cycles = 0;

  // Apply one row to the shadow state and return what the block should report for it.
  function automatic slot_result_t fold_row_into_slot(row_item_t r);
    logic [gau_pkg::COUNT_W-1:0]        old_count;
    logic [gau_pkg::COUNT_W-1:0]        new_count;
    logic signed [gau_pkg::VALUE_W-1:0] old_value;
    logic signed [gau_pkg::VALUE_W-1:0] new_value;
    logic signed [gau_pkg::VALUE_W-1:0] arg;
    logic signed [gau_pkg::VALUE_W-1:0] total;
    logic                               counted;
    slot_result_t                       res;
    arg       = r.value;  // Q31.16 -> Q47.16 is a plain sign extension
    old_count = count_mirror[r.slot];
    old_value = value_mirror[r.slot];
    new_value = old_value;
    counted   = 1'b0;
    case (agg_mode_mirror)
      gau_pkg::MODE_COUNT_ALL:   counted = 1'b1;
      gau_pkg::MODE_COUNT_VALID: counted = r.vvalid;
      gau_pkg::MODE_SUM: begin
        if (r.vvalid) begin
          counted = 1'b1;
          total   = old_value + arg;
          // Same-sign operands whose sum flips sign have overflowed: clamp.
          if (old_value[gau_pkg::VALUE_W-1] == arg[gau_pkg::VALUE_W-1] &&
              total[gau_pkg::VALUE_W-1] != old_value[gau_pkg::VALUE_W-1])
            total = old_value[gau_pkg::VALUE_W-1] ? gau_pkg::VALUE_NEG_MAX
                                                  : gau_pkg::VALUE_POS_MAX;
          new_value = total;
        end
      end
      gau_pkg::MODE_MIN: begin
        if (r.vvalid) begin
          counted   = 1'b1;
          new_value = (old_count == 0 || arg < old_value) ? arg : old_value;
        end
      end
      gau_pkg::MODE_MAX: begin
        if (r.vvalid) begin
          counted   = 1'b1;
          new_value = (old_count == 0 || arg > old_value) ? arg : old_value;
        end
      end
      default: ;
    endcase
    new_count = (counted && old_count != gau_pkg::COUNT_MAX) ? old_count + 1'b1 : old_count;
    count_mirror[r.slot] = new_count;
    value_mirror[r.slot] = new_value;
    res.count   = new_count;
    res.value   = new_value;
    res.changed = (new_count != old_count) || (new_value != old_value);
    res.done    = r.last;
    return res;
  endfunction

  function automatic void compare_field(string what, logic [gau_pkg::VALUE_W-1:0] want,
                                        logic [gau_pkg::VALUE_W-1:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endfunction

  function automatic void queue_row(int unsigned slot, longint value, bit vvalid, bit last);
    row_item_t r;
    r.slot   = slot[gau_pkg::SLOT_W-1:0];
    r.value  = value[gau_pkg::ROW_W-1:0];
    r.vvalid = vvalid;
    r.last   = last;
    rows_to_send.push_back(r);
  endfunction

  // Random rows: most land on a handful of slots so counts and extremes build up and
  // back-to-back hits on one slot are common; values lean on the extremes.
  function automatic void queue_random_rows(int unsigned n);
    int unsigned pick;
    int unsigned slot;
    longint      value;
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 55)      slot = $urandom_range(7);
      else if (pick < 60) slot = 0;
      else if (pick < 65) slot = SLOT_COUNT - 1;
      else                slot = $urandom_range(SLOT_COUNT - 1);
      pick = $urandom_range(99);
      if (pick < 10)      value = ROW_POS_MAX;
      else if (pick < 20) value = ROW_NEG_MAX;
      else if (pick < 45) value = int'($urandom_range(2000)) - 1000;
      else                value = {$urandom, $urandom};
      queue_row(slot, value, $urandom_range(3) != 0, $urandom_range(7) == 0);
    end
  endfunction

  // Hold until every queued row is taken and every owed result has come back.
  task automatic wait_drained();
    do @(negedge clk);
    while (rows_to_send.size() != 0 || in_ch.valid || slot_updates_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Call only while the block is idle.
  task automatic write_mode(input logic [gau_pkg::MODE_W-1:0] mode);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    @(negedge clk);
  endtask

  // Row driver: advance to the next queued row once the current one is taken,
  // or drop valid for a cycle when the queue is empty or the idle draw says so.
  always @(posedge clk) begin : drive_rows
    row_item_t next_row;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (rows_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_row          = rows_to_send.pop_front();
        in_ch.valid       <= 1'b1;
        in_ch.group_slot  <= next_row.slot;
        in_ch.row_value   <= next_row.value;
        in_ch.value_valid <= next_row.vvalid;
        in_ch.batch_last  <= next_row.last;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver: stall at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: track mode writes, predict each accepted row, check each accepted result.
  // Prediction runs before the check in the same block, so ordering within a step is fixed.
  always @(posedge clk) begin : watch_channels
    row_item_t    seen_row;
    slot_result_t want;
    if (!rst_n) begin
      agg_mode_mirror = gau_pkg::MODE_COUNT_ALL;
    end else begin
      if (cfg_wr_en)
        agg_mode_mirror = cfg_wr_data;
      if (in_ch.valid && in_ch.ready) begin
        seen_row.slot   = in_ch.group_slot;
        seen_row.value  = in_ch.row_value;
        seen_row.vvalid = in_ch.value_valid;
        seen_row.last   = in_ch.batch_last;
        slot_updates_due.push_back(fold_row_into_slot(seen_row));
        rows_accepted++;
      end
      if (out_ch.valid && out_ch.ready) begin
        results_checked++;
        if (slot_updates_due.size() == 0) begin
          mismatch_count++;
          $display("%0t ns: unexpected result, expected none, actual count %0h value %0h",
                   $time, out_ch.slot_count, out_ch.slot_value);
        end else begin
          want = slot_updates_due.pop_front();
          compare_field("slot_count", want.count, out_ch.slot_count);
          compare_field("slot_value", want.value, out_ch.slot_value);
          compare_field("slot_changed", want.changed, out_ch.slot_changed);
          compare_field("batch_done", want.done, out_ch.batch_done);
        end
      end
    end
  end

  // Watchdog: end the run if no handshake happens for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no handshake for %0d cycles", $time, stall_cycles);
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [gau_pkg::MODE_W-1:0] block_mode [RANDOM_BLOCKS];
    int                         blk_idx;
    int unsigned                mode_pick;

    // Known values on every input from time zero.
    rst_n             = 1'b0;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = gau_pkg::MODE_COUNT_ALL;
    in_ch.valid       = 1'b0;
    in_ch.group_slot  = '0;
    in_ch.row_value   = '0;
    in_ch.value_valid = 1'b0;
    in_ch.batch_last  = 1'b0;
    out_ch.ready      = 1'b0;
    send_idle_pct     = 33;
    recv_idle_pct     = 71;
    block_mode = '{gau_pkg::MODE_SUM, gau_pkg::MODE_MIN, gau_pkg::MODE_MAX,
                   gau_pkg::MODE_COUNT_VALID, gau_pkg::MODE_SUM, gau_pkg::MODE_MAX,
                   gau_pkg::MODE_MIN, gau_pkg::MODE_COUNT_ALL, gau_pkg::MODE_COUNT_ALL};
    mode_pick = $urandom_range(7);
    block_mode[RANDOM_BLOCKS-1] = mode_pick[gau_pkg::MODE_W-1:0];

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // Rows queued now sit until the clearing pass lets in_ch.ready rise.

    // Count every row, mode as left by reset: null rows count, extreme slots,
    // three back-to-back hits on one slot through the forwarding path.
    queue_row(0, ROW_NEG_MAX, 1'b0, 1'b0);
    queue_row(SLOT_COUNT - 1, ROW_POS_MAX, 1'b1, 1'b1);
    repeat (3) queue_row(5, 0, 1'b1, 1'b0);
    wait_drained();

    // Count valid rows: a null row leaves the slot alone.
    write_mode(gau_pkg::MODE_COUNT_VALID);
    queue_row(5, 0, 1'b0, 1'b0);
    queue_row(5, -1, 1'b1, 1'b1);
    wait_drained();

    // Sum: full-scale values of both signs, a null row, alternating bit patterns.
    write_mode(gau_pkg::MODE_SUM);
    queue_row(7, ROW_POS_MAX, 1'b1, 1'b0);
    queue_row(7, ROW_NEG_MAX, 1'b1, 1'b0);
    queue_row(7, 123, 1'b0, 1'b0);
    queue_row(7, -1, 1'b1, 1'b1);
    queue_row(SLOT_COUNT - 1, 48'sh5555_5555_5555, 1'b1, 1'b0);
    queue_row(0, 48'shAAAA_AAAA_AAAA, 1'b1, 1'b1);
    wait_drained();

    // Minimum: first valid value seeds an empty slot, then folds; slot 5 already
    // holds a count from the counting modes, so its zero value is kept.
    write_mode(gau_pkg::MODE_MIN);
    queue_row(100, 1000, 1'b1, 1'b0);
    queue_row(100, 2000, 1'b1, 1'b0);
    queue_row(100, -3, 1'b1, 1'b0);
    queue_row(100, ROW_NEG_MAX, 1'b0, 1'b0);
    queue_row(5, 42, 1'b1, 1'b1);
    wait_drained();

    // Maximum: seed an empty slot with a negative value, then fold.
    write_mode(gau_pkg::MODE_MAX);
    queue_row(101, -500, 1'b1, 1'b0);
    queue_row(101, -7, 1'b1, 1'b0);
    queue_row(101, ROW_NEG_MAX, 1'b1, 1'b0);
    queue_row(100, ROW_POS_MAX, 1'b1, 1'b1);
    wait_drained();

    // Undefined modes: state is reported but never touched.
    write_mode(MODE_UNDEF_HI);
    queue_row(7, ROW_POS_MAX, 1'b1, 1'b0);
    queue_row(SLOT_COUNT - 1, 0, 1'b0, 1'b1);
    wait_drained();
    write_mode(MODE_UNDEF_LO);
    queue_row(0, 1, 1'b1, 1'b0);
    wait_drained();
    write_mode(MODE_UNDEF_MID);
    queue_row(0, 1, 1'b1, 1'b1);
    wait_drained();

    // Random blocks, one mode each; swap the idle profile a third of the way in,
    // then drop idling altogether for the last third.
    for (blk_idx = 0; blk_idx < RANDOM_BLOCKS; blk_idx++) begin
      wait_drained();
      if (blk_idx == RANDOM_BLOCKS / 3) begin
        send_idle_pct = 71;
        recv_idle_pct = 33;
      end else if (blk_idx == 2 * RANDOM_BLOCKS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_mode(block_mode[blk_idx]);
      if (blk_idx == RANDOM_BLOCKS / 3 + 1) begin
        // Hold the sender mid-block until the block has returned everything.
        queue_random_rows(BLOCK_ROWS / 2);
        wait_drained();
        queue_random_rows(BLOCK_ROWS - BLOCK_ROWS / 2);
      end else begin
        queue_random_rows(BLOCK_ROWS);
      end
    end
    wait_drained();

    $display("Run covered %0d rows and %0d results: all eight mode codes, null rows,",
             rows_accepted, results_checked);
    $display("slot extremes, same-slot back-to-back rows and full-scale values of both signs");
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
